### hw/rtl/fdiv_pkg.sv
`default_nettype none

package fdiv_pkg;

    localparam int FIELD_W = 64;

    typedef logic signed [FIELD_W-1:0] field_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        logic    floor_mode;
        logic    an;
        logic    bn;
        status_t status;
    } ctl_t;

endpackage

`default_nettype wire

### hw/rtl/floor_truncate_divider.sv
// Signed divider, truncating or floor rounding, pipelined as a chain of cells.
// Request channel: a word (req_type, dividend, divisor) is taken at every rising
// edge with start high; busy stays low, so a new word may be offered in every
// cycle. Only the low DATA_WIDTH bits of dividend and divisor are used.
// Result channel: done is high for exactly one cycle with quotient, remainder
// and status; quotient and remainder are sign-extended from DATA_WIDTH bits.
// Status: 0 ok, 1 divide by zero (quotient and remainder zero), 2 minimum
// divided by minus one (quotient wraps to the minimum, remainder zero).
// Stages: one operand stage, one restoring cell per quotient bit, and one sign and
// floor stage, each registered; a word passes them in that order before done.
// Throughput: one word per cycle; each cell resolves one quotient bit of one
// word and hands it on, so DATA_WIDTH + 2 words may be in flight.
// Results appear in request order. The receiver cannot stall: done is a strobe.
// Reset clears every valid flag in the chain; words in flight are dropped.
`default_nettype none

module floor_truncate_divider #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           req_type,
    input  wire logic signed [fdiv_pkg::FIELD_W-1:0] dividend,
    input  wire logic signed [fdiv_pkg::FIELD_W-1:0] divisor,
    output logic                                done,
    output logic signed [fdiv_pkg::FIELD_W-1:0] quotient,
    output logic signed [fdiv_pkg::FIELD_W-1:0] remainder,
    output logic [1:0]                          status
);

    fdiv_pkg::ctl_t        ctl_chain [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rem_chain [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] aq_chain  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] dv_chain  [DATA_WIDTH+1];

    assign busy         = 1'b0;
    assign rem_chain[0] = '0;

    fdiv_prep #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (start && !busy),
        .req_type(req_type),
        .dividend(dividend),
        .divisor (divisor),
        .ctl     (ctl_chain[0]),
        .ma      (aq_chain[0]),
        .mb      (dv_chain[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        fdiv_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl_in (ctl_chain[i]),
            .rem_in (rem_chain[i]),
            .aq_in  (aq_chain[i]),
            .dv_in  (dv_chain[i]),
            .ctl_out(ctl_chain[i+1]),
            .rem_out(rem_chain[i+1]),
            .aq_out (aq_chain[i+1]),
            .dv_out (dv_chain[i+1])
        );
    end

    fdiv_post #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_chain[DATA_WIDTH]),
        .rmag     (rem_chain[DATA_WIDTH]),
        .qmag     (aq_chain[DATA_WIDTH]),
        .mb       (dv_chain[DATA_WIDTH]),
        .done     (done),
        .quotient (quotient),
        .remainder(remainder),
        .status   (status)
    );

endmodule

`default_nettype wire

### hw/rtl/fdiv_prep.sv
`default_nettype none

module fdiv_prep #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            req_type,
    input  wire logic signed [fdiv_pkg::FIELD_W-1:0] dividend,
    input  wire logic signed [fdiv_pkg::FIELD_W-1:0] divisor,
    output fdiv_pkg::ctl_t                       ctl,
    output logic [DATA_WIDTH-1:0]                ma,
    output logic [DATA_WIDTH-1:0]                mb
);

    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    fdiv_pkg::ctl_t        ctl_reg;
    fdiv_pkg::ctl_t        ctl_next;
    logic [DATA_WIDTH-1:0] ma_reg;
    logic [DATA_WIDTH-1:0] ma_next;
    logic [DATA_WIDTH-1:0] mb_reg;
    logic [DATA_WIDTH-1:0] mb_next;

    always_comb
    begin
        a = dividend[DATA_WIDTH-1:0];
        b = divisor[DATA_WIDTH-1:0];
        ctl_next.valid      = accept;
        ctl_next.floor_mode = req_type;
        ctl_next.an         = a[DATA_WIDTH-1];
        ctl_next.bn         = b[DATA_WIDTH-1];
        if (b == '0)
        begin
            ctl_next.status = fdiv_pkg::ST_DIV_ZERO;
        end
        else if (a == MIN_VAL && b == ALL_ONES)
        begin
            ctl_next.status = fdiv_pkg::ST_OVERFLOW;
        end
        else
        begin
            ctl_next.status = fdiv_pkg::ST_OK;
        end
        ma_next = a[DATA_WIDTH-1] ? DATA_WIDTH'(~a + DATA_WIDTH'(1)) : a;
        mb_next = b[DATA_WIDTH-1] ? DATA_WIDTH'(~b + DATA_WIDTH'(1)) : b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= ma_next;
        mb_reg <= mb_next;
    end

    assign ctl = ctl_reg;
    assign ma  = ma_reg;
    assign mb  = mb_reg;

endmodule

`default_nettype wire

### hw/rtl/fdiv_cell.sv
`default_nettype none

module fdiv_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fdiv_pkg::ctl_t    ctl_in,
    input  wire logic [DATA_WIDTH-1:0] rem_in,
    input  wire logic [DATA_WIDTH-1:0] aq_in,
    input  wire logic [DATA_WIDTH-1:0] dv_in,
    output fdiv_pkg::ctl_t         ctl_out,
    output logic [DATA_WIDTH-1:0]  rem_out,
    output logic [DATA_WIDTH-1:0]  aq_out,
    output logic [DATA_WIDTH-1:0]  dv_out
);

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH+1:0] diff;
    logic                  ge;
    fdiv_pkg::ctl_t        ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] aq_reg;
    logic [DATA_WIDTH-1:0] aq_next;
    logic [DATA_WIDTH-1:0] dv_reg;

    // one restoring step: shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial    = {rem_in, aq_in[DATA_WIDTH-1]};
        diff     = {1'b0, trial} - {2'b00, dv_in};
        ge       = !diff[DATA_WIDTH+1];
        rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        aq_next  = {aq_in[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        aq_reg  <= aq_next;
        dv_reg  <= dv_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign aq_out  = aq_reg;
    assign dv_out  = dv_reg;

endmodule

`default_nettype wire

### hw/rtl/fdiv_post.sv
`default_nettype none

module fdiv_post #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fdiv_pkg::ctl_t                   ctl_in,
    input  wire logic [DATA_WIDTH-1:0]            rmag,
    input  wire logic [DATA_WIDTH-1:0]            qmag,
    input  wire logic [DATA_WIDTH-1:0]            mb,
    output logic                                  done,
    output logic signed [fdiv_pkg::FIELD_W-1:0]   quotient,
    output logic signed [fdiv_pkg::FIELD_W-1:0]   remainder,
    output logic [1:0]                            status
);

    logic                         neg_q;
    logic                         adj;
    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] q_reg;
    logic signed [DATA_WIDTH-1:0] q_next;
    logic signed [DATA_WIDTH-1:0] r_reg;
    logic signed [DATA_WIDTH-1:0] r_next;
    fdiv_pkg::status_t            status_reg;

    // floor correction: q - 1 on a negated quotient is just its inversion
    always_comb
    begin
        neg_q = ctl_in.an ^ ctl_in.bn;
        adj   = ctl_in.floor_mode && neg_q && (rmag != '0);
        if (ctl_in.status == fdiv_pkg::ST_DIV_ZERO)
        begin
            q_next = '0;
            r_next = '0;
        end
        else
        begin
            if (!neg_q)
            begin
                q_next = qmag;
            end
            else if (adj)
            begin
                q_next = ~qmag;
            end
            else
            begin
                q_next = DATA_WIDTH'(~qmag + DATA_WIDTH'(1));
            end
            if (adj)
            begin
                r_next = ctl_in.bn ? DATA_WIDTH'(rmag - mb) : DATA_WIDTH'(mb - rmag);
            end
            else
            begin
                r_next = ctl_in.an ? DATA_WIDTH'(~rmag + DATA_WIDTH'(1)) : rmag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        r_reg      <= r_next;
        status_reg <= ctl_in.status;
    end

    assign done      = done_reg;
    assign quotient  = fdiv_pkg::field_t'(q_reg);
    assign remainder = fdiv_pkg::field_t'(r_reg);
    assign status    = status_reg;

endmodule

`default_nettype wire

### hw/rtl/fdiv_checker.sv
`default_nettype none

module fdiv_checker #(
    parameter int DATA_WIDTH = 64
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                done,
    input wire logic signed [fdiv_pkg::FIELD_W-1:0] quotient,
    input wire logic signed [fdiv_pkg::FIELD_W-1:0] remainder,
    input wire logic [1:0]                          status
);

    localparam int LATENCY = DATA_WIDTH + 2;

    // every accepted word comes back after the fixed latency
    a_word_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not return on time");

    // no result without a matching request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fdiv_pkg::ST_DIV_ZERO) |-> (quotient == '0 && remainder == '0))
        else $error("divide by zero gave nonzero results");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fdiv_pkg::ST_OVERFLOW) |-> (remainder == '0 && quotient[fdiv_pkg::FIELD_W-1]))
        else $error("overflow result malformed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == fdiv_pkg::ST_OK || status == fdiv_pkg::ST_DIV_ZERO
                  || status == fdiv_pkg::ST_OVERFLOW))
        else $error("unused status code");

endmodule

bind floor_truncate_divider fdiv_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_fdiv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .quotient (quotient),
    .remainder(remainder),
    .status   (status)
);

`default_nettype wire

### sim/floor_truncate_divider_test.sv
module floor_truncate_divider_test;

    localparam int FIELD_W = fdiv_pkg::FIELD_W;
    typedef fdiv_pkg::field_t  field_t;
    typedef fdiv_pkg::status_t status_t;

    localparam int DIV_WIDTH = FIELD_W;
    localparam int LATENCY = DIV_WIDTH + 2;
    localparam logic MODE_TRUNC = 1'b0;
    localparam logic MODE_FLOOR = 1'b1;
    localparam field_t VAL_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam field_t VAL_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam field_t VAL_ZERO = '0;
    localparam field_t VAL_ONE = field_t'(1);
    localparam field_t VAL_NEG_ONE = '1;

    typedef struct packed {
        field_t  quot;
        field_t  rem;
        status_t st;
    } division_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    logic   req_type;
    field_t dividend;
    field_t divisor;
    logic   done;
    field_t quotient;
    field_t remainder;
    logic [1:0] status;

    division_t   pending_divisions[$];
    int unsigned mismatch_count = 0;
    bit          gaps_on = 1'b1;

    floor_truncate_divider #(
        .DATA_WIDTH (DIV_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (done),
        .quotient  (quotient),
        .remainder (remainder),
        .status    (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic division_t floor_trunc_divide(input logic floor_mode,
                                                     input field_t num, input field_t den);
        division_t          res;
        logic [FIELD_W-1:0] un;
        logic [FIELD_W-1:0] ud;
        logic [FIELD_W-1:0] mag_n;
        logic [FIELD_W-1:0] mag_d;
        logic [FIELD_W-1:0] q;
        logic [FIELD_W-1:0] r;
        logic               neg_n;
        logic               neg_d;
        un = num;
        ud = den;
        neg_n = un[FIELD_W-1];
        neg_d = ud[FIELD_W-1];
        if (ud == '0)
        begin
            res.quot = VAL_ZERO;
            res.rem  = VAL_ZERO;
            res.st   = fdiv_pkg::ST_DIV_ZERO;
        end
        else if (num == VAL_MIN && den == VAL_NEG_ONE)
        begin
            res.quot = VAL_MIN;
            res.rem  = VAL_ZERO;
            res.st   = fdiv_pkg::ST_OVERFLOW;
        end
        else
        begin
            mag_n = neg_n ? -un : un;
            mag_d = neg_d ? -ud : ud;
            q = mag_n / mag_d;
            r = mag_n % mag_d;
            if (neg_n != neg_d)
                q = -q;
            if (neg_n)
                r = -r;
            // floor: pull down whenever the remainder disagrees in sign with the divisor
            if (floor_mode && r != '0 && neg_n != neg_d)
            begin
                q = q - 1'b1;
                r = r + ud;
            end
            res.quot = q;
            res.rem  = r;
            res.st   = fdiv_pkg::ST_OK;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        division_t want;
        if (rst_n && done)
        begin
            if (pending_divisions.size() == 0)
                report_mismatch("result with no word outstanding", quotient, 64'd0);
            else
            begin
                want = pending_divisions.pop_front();
                if (quotient !== want.quot)
                    report_mismatch("quotient", quotient, want.quot);
                if (remainder !== want.rem)
                    report_mismatch("remainder", remainder, want.rem);
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 50)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic send_word(input logic mode, input field_t num, input field_t den);
        int unsigned gap;
        if (!start)
            start <= 1'b1;
        req_type <= mode;
        dividend <= num;
        divisor  <= den;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_divisions.push_back(floor_trunc_divide(mode, num, den));
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results(input int unsigned max_cycles);
        int unsigned waited;
        waited = 0;
        if (start)
            start <= 1'b0;
        while (pending_divisions.size() != 0 && waited < max_cycles)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic field_t pick_value();
        field_t v;
        case ($urandom_range(0, 5))
            0, 1: v = {$urandom, $urandom};
            2: v = field_t'($urandom_range(0, 40)) - field_t'(20);
            3:
            begin
                case ($urandom_range(0, 7))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MIN + 1;
                    3: v = VAL_MAX - 1;
                    4: v = VAL_ONE;
                    5: v = VAL_NEG_ONE;
                    6: v = field_t'(2);
                    default: v = -field_t'(2);
                endcase
            end
            default:
            begin
                v = {$urandom, $urandom} >> $urandom_range(1, 63);
                if ($urandom_range(0, 1) != 0)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_random_word();
        field_t num;
        field_t den;
        logic   mode;
        mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 39))
            0: den = VAL_ZERO;
            1, 2, 3: den = ($urandom_range(0, 1) != 0) ? VAL_ONE : VAL_NEG_ONE;
            default: den = pick_value();
        endcase
        case ($urandom_range(0, 29))
            0:
            begin
                num = VAL_MIN;
                den = VAL_NEG_ONE;
            end
            1, 2, 3, 4: num = den * (field_t'($urandom_range(0, 200)) - field_t'(100));
            // dividend close to the divisor in magnitude
            5, 6, 7: num = den + (field_t'($urandom_range(0, 6)) - field_t'(3));
            default: num = pick_value();
        endcase
        send_word(mode, num, den);
    endtask

    task automatic test_directed();
        int m;
        for (m = 0; m < 2; m++)
        begin
            send_word(logic'(m), VAL_ZERO, VAL_ZERO);
            send_word(logic'(m), VAL_MIN, VAL_NEG_ONE);
            send_word(logic'(m), -field_t'(7), field_t'(2));
            send_word(logic'(m), field_t'(7), -field_t'(2));
            // zero truncated quotient with mixed signs
            send_word(logic'(m), -field_t'(1), field_t'(5));
            send_word(logic'(m), field_t'(1), -field_t'(5));
            send_word(logic'(m), VAL_MAX, VAL_MIN);
        end
        send_word(MODE_TRUNC, VAL_MAX, VAL_ZERO);
        send_word(MODE_FLOOR, VAL_MIN, VAL_ZERO);
        send_word(MODE_TRUNC, VAL_MAX, VAL_ONE);
        send_word(MODE_FLOOR, VAL_MIN, VAL_ONE);
        send_word(MODE_TRUNC, VAL_MIN, VAL_MIN);
        send_word(MODE_FLOOR, VAL_MAX, VAL_NEG_ONE);
        send_word(MODE_FLOOR, VAL_MIN, VAL_MAX);
        send_word(MODE_FLOOR, -field_t'(5), -field_t'(3));
        send_word(MODE_FLOOR, field_t'(3), field_t'(7));
        send_word(MODE_FLOOR, VAL_ZERO, -field_t'(5));
        send_word(MODE_TRUNC, VAL_MIN + 1, VAL_NEG_ONE);
        send_word(MODE_FLOOR, -field_t'(12), field_t'(4));
        drain_results(LATENCY * 4);
    endtask

    task automatic test_random();
        int blk;
        int n;
        for (blk = 0; blk < 4; blk++)
        begin
            // first block runs back to back
            gaps_on = (blk != 0);
            for (n = 0; n < 125; n++)
                send_random_word();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_then_burst();
        int n;
        drain_results(LATENCY * 4);
        gaps_on = 1'b0;
        for (n = 0; n < 30; n++)
            send_random_word();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        req_type <= MODE_TRUNC;
        dividend <= VAL_ZERO;
        divisor  <= VAL_ZERO;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_drain_then_burst();
        drain_results(LATENCY * 20);
        repeat (LATENCY + 4) @(posedge clk);
        while (pending_divisions.size() != 0)
        begin
            void'(pending_divisions.pop_front());
            report_mismatch("result never arrived", 64'd0, 64'd0);
        end
        if (mismatch_count == 0)
            $display("floor_truncate_divider: match");
        else
            $display("floor_truncate_divider: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("floor_truncate_divider: mismatch");
        $finish;
    end

endmodule

### files.f
hw/rtl/fdiv_pkg.sv
hw/rtl/fdiv_prep.sv
hw/rtl/fdiv_cell.sv
hw/rtl/fdiv_post.sv
hw/rtl/floor_truncate_divider.sv
hw/rtl/fdiv_checker.sv
sim/floor_truncate_divider_test.sv
